FILE: rtl/core/b32c_pkg.sv
// shared constants, types and reset alphabet of the base32 codec
`timescale 1ns / 1ps

package b32c_pkg;

  localparam int AlphaLen = 32;
  localparam int NumWords = 8;
  localparam int ChPerWord = 4;
  localparam int ByteW = 8;
  localparam int SymW = 5;
  localparam int StoreW = 12;
  localparam int HeldW = 4;
  localparam int CfgIdxW = 4;
  localparam int CfgDataW = 32;
  localparam int MaxRes = 3;
  localparam int CntW = 2;
  localparam int QDepth = 4;
  localparam int QPtrW = 2;
  localparam int QCntW = 3;

  // input action codes
  localparam logic ActEncode = 1'b0;
  localparam logic ActDecode = 1'b1;

  // entry 0 sits in the low byte
  typedef logic [AlphaLen-1:0][ByteW-1:0] alphabet_t;

  localparam alphabet_t AlphaReset = {
    32'h36353433, 32'h32315A59, 32'h58575655, 32'h54535251,
    32'h504F4E4D, 32'h4C4B4A49, 32'h48474645, 32'h44434241
  };

  // one item's worth of results as passed from front to back
  typedef struct packed {
    logic [CntW-1:0]              cnt;
    logic [MaxRes-1:0][ByteW-1:0] vals;
    logic                         sym;
    logic                         bad;
    logic                         eom;
  } q_entry_t;

  // low-bit mask of a given number of held bits
  function automatic logic [StoreW-1:0] held_mask(input logic [HeldW-1:0] n);
    held_mask = StoreW'((StoreW'(1) << n) - StoreW'(1));
  endfunction

endpackage

FILE: rtl/core/b32c_if.sv
// channel interfaces of the base32 codec: input items, results, register writes
`timescale 1ns / 1ps

interface b32c_in_if import b32c_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [ByteW-1:0] data_in;
  logic             last_item;

  modport source (output valid, action, data_in, last_item, input ready);
  modport sink (input valid, action, data_in, last_item, output ready);
endinterface

interface b32c_out_if import b32c_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] value_out;
  logic             bad_symbol;
  logic             end_of_run;
  logic             end_of_message;

  modport source (output valid, value_out, bad_symbol, end_of_run, end_of_message,
                  input ready);
  modport sink (input valid, value_out, bad_symbol, end_of_run, end_of_message,
                output ready);
endinterface

interface b32c_cfg_if import b32c_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/b32c_front.sv
// front end: accepts items, keeps the bit store and builds result records
`timescale 1ns / 1ps

module b32c_front import b32c_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  b32c_in_if.sink    in_ch,
  input  alphabet_t  alpha,
  input  logic       q_full,
  output logic       q_push,
  output q_entry_t   q_entry
);

  logic [StoreW-1:0] store_r, store_nxt;
  logic [HeldW-1:0]  held_r, held_nxt;
  logic              err_r, err_nxt;

  logic              accept;

  // encode path
  logic [StoreW-1:0] enc_s;
  logic [HeldW-1:0]  enc_h, enc_h1, enc_h2;
  logic              enc_two, enc_flush;
  logic [SymW-1:0]   enc_r0, enc_r1, enc_rf;

  // decode path
  logic [AlphaLen-1:0] match, lowest;
  logic [SymW-1:0]     dec_idx;
  logic                dec_found;
  logic [StoreW-1:0]   dec_s;
  logic [HeldW-1:0]    dec_h, dec_h2;
  logic                dec_emit;
  logic [ByteW-1:0]    dec_val;

  assign in_ch.ready = ~q_full;
  assign accept = in_ch.valid & in_ch.ready;

  // encode: cut to four held bits, append the byte, split into 5-bit groups
  always_comb begin
    enc_s   = {store_r[3:0], in_ch.data_in};
    enc_h   = ((held_r > 4'd4) ? 4'd4 : held_r) + HeldW'(ByteW);
    enc_h1  = enc_h - HeldW'(SymW);
    enc_r0  = SymW'(enc_s >> enc_h1);
    enc_two = (enc_h1 >= HeldW'(SymW));
    enc_h2  = enc_two ? (enc_h1 - HeldW'(SymW)) : enc_h1;
    enc_r1  = SymW'(enc_s >> enc_h2);
    enc_flush = in_ch.last_item && (enc_h2 != '0);
    enc_rf  = SymW'(enc_s << (HeldW'(SymW) - enc_h2));
  end

  // decode: match against the alphabet, lowest index wins
  always_comb begin
    for (int i = 0; i < AlphaLen; i++) begin
      match[i] = (alpha[i] == in_ch.data_in);
    end
    lowest = match & (~match + AlphaLen'(1));
    for (int b = 0; b < SymW; b++) begin
      dec_idx[b] = 1'b0;
      for (int i = 0; i < AlphaLen; i++) begin
        if (((i >> b) & 1) == 1) dec_idx[b] = dec_idx[b] | lowest[i];
      end
    end
    dec_found = |match;
    dec_s     = {store_r[6:0], dec_idx};
    dec_h     = held_r + HeldW'(SymW);
    dec_emit  = (dec_h >= HeldW'(ByteW));
    dec_h2    = dec_emit ? (dec_h - HeldW'(ByteW)) : dec_h;
    dec_val   = ByteW'(dec_s >> dec_h2);
  end

  // next state and the record handed to the queue
  always_comb begin
    store_nxt = store_r;
    held_nxt  = held_r;
    err_nxt   = err_r;
    q_push    = 1'b0;
    q_entry   = '0;
    q_entry.eom = in_ch.last_item;
    if (accept) begin
      if (err_r) begin
        // dropping until the end of the message
      end else if (in_ch.action == ActEncode) begin
        q_push        = 1'b1;
        q_entry.sym   = 1'b1;
        q_entry.cnt   = CntW'(1) + CntW'(enc_two) + CntW'(enc_flush);
        q_entry.vals[0] = ByteW'(enc_r0);
        q_entry.vals[1] = enc_two ? ByteW'(enc_r1) : ByteW'(enc_rf);
        q_entry.vals[2] = ByteW'(enc_rf);
        held_nxt  = enc_flush ? '0 : enc_h2;
        store_nxt = enc_s & held_mask(held_nxt);
      end else if (!dec_found) begin
        q_push      = 1'b1;
        q_entry.bad = 1'b1;
        q_entry.cnt = CntW'(1);
        err_nxt     = 1'b1;
      end else begin
        q_push      = dec_emit;
        q_entry.cnt = CntW'(1);
        q_entry.vals[0] = dec_val;
        held_nxt  = dec_h2;
        store_nxt = dec_s & held_mask(dec_h2);
      end
      if (in_ch.last_item) begin
        store_nxt = '0;
        held_nxt  = '0;
        err_nxt   = 1'b0;
      end
    end
  end

  // message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      held_r  <= '0;
      err_r   <= 1'b0;
    end else begin
      store_r <= store_nxt;
      held_r  <= held_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

FILE: rtl/core/b32c_queue.sv
// short record queue between front and back
`timescale 1ns / 1ps

module b32c_queue import b32c_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  output logic     head_valid,
  output q_entry_t head,
  input  logic     pop
);

  q_entry_t           slots [QDepth];
  logic [QPtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0]   count_r, count_nxt;

  assign full       = (count_r == QCntW'(QDepth));
  assign head_valid = (count_r != '0);
  assign head       = slots[rd_ptr_r];

  // pointer and fill tracking
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPtrW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPtrW'(1) : rd_ptr_r;
    count_nxt  = count_r + QCntW'(push) - QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // record storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr_r] <= push_entry;
  end

endmodule

FILE: rtl/core/b32c_back.sv
// back end: walks each record one result at a time into the output register
`timescale 1ns / 1ps

module b32c_back import b32c_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  alphabet_t  alpha,
  input  logic       head_valid,
  input  q_entry_t   head,
  output logic       pop,
  b32c_out_if.source out_ch
);

  logic [CntW-1:0]  sub_r, sub_nxt;
  logic             ov_r, ov_nxt;
  logic [ByteW-1:0] val_r, val_nxt;
  logic             bad_r, eor_r, eom_r;

  logic             load, last_of;
  logic [ByteW-1:0] raw;

  assign load    = head_valid && (!ov_r || out_ch.ready);
  assign last_of = (sub_r == CntW'(head.cnt - CntW'(1)));
  assign pop     = load && last_of;

  // pick the current slot and map symbols through the alphabet
  always_comb begin
    case (sub_r)
      2'd0:    raw = head.vals[0];
      2'd1:    raw = head.vals[1];
      2'd2:    raw = head.vals[2];
      default: raw = '0;
    endcase
    if (head.bad) val_nxt = '0;
    else if (head.sym) val_nxt = alpha[raw[SymW-1:0]];
    else val_nxt = raw;
  end

  // sequencing and output valid
  always_comb begin
    sub_nxt = sub_r;
    ov_nxt  = ov_r;
    if (load) begin
      sub_nxt = last_of ? '0 : sub_r + CntW'(1);
      ov_nxt  = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
      ov_r  <= ov_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      val_r <= val_nxt;
      bad_r <= head.bad;
      eor_r <= last_of;
      eom_r <= head.eom;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.value_out      = val_r;
  assign out_ch.bad_symbol     = bad_r;
  assign out_ch.end_of_run     = eor_r;
  assign out_ch.end_of_message = eom_r;

endmodule

FILE: rtl/core/base32_codec_custom_alphabet.sv
// top level of the unpadded base32 codec with a programmable alphabet
//
// Channels: in_ch takes one transaction per item (action 0 encodes a raw
// byte, action 1 decodes an alphabet character, last_item closes the
// message). out_ch gives one transaction per result: an alphabet character
// or decoded byte, a bad symbol flag, and end-of-run / end-of-message marks.
// cfg_ch writes the eight 32-bit alphabet words; it is always ready and
// indexes of eight and above are ignored.
// Throughput: the front end takes one item per cycle while the four-entry
// record queue has room. The output register sends one result per cycle
// while out_ch is ready, so an encode item that yields two or three results
// holds out_ch for each of them; the result channel sets the sustained rate.
// Path: each record is registered in a queue slot, and each of its results
// is then registered in the output register, in order.
// Stalls: while out_ch is not ready the queue fills; in_ch drops ready once
// four records wait. Nothing is lost.
// Reset: rst_n clears the bit store, error flag, queue and output valid and
// reloads the default alphabet A to Z then 1 to 6.
`timescale 1ns / 1ps

module base32_codec_custom_alphabet import b32c_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  b32c_in_if.sink    in_ch,
  b32c_out_if.source out_ch,
  b32c_cfg_if.sink   cfg_ch
);

  alphabet_t alpha_r, alpha_nxt;
  logic      q_push, q_full, q_head_valid, q_pop;
  q_entry_t  q_entry, q_head;

  // alphabet registers
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    alpha_nxt = alpha_r;
    if (cfg_ch.valid) begin
      for (int w = 0; w < NumWords; w++) begin
        if (cfg_ch.index == CfgIdxW'(w)) begin
          alpha_nxt[w*ChPerWord +: ChPerWord] = cfg_ch.data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= AlphaReset;
    end else begin
      alpha_r <= alpha_nxt;
    end
  end

  b32c_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .alpha   (alpha_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  b32c_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  b32c_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .alpha      (alpha_r),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

  // no record is written into a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("record pushed into full queue");

  // records leave only when one is waiting
  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head_valid)
    else $error("pop from empty queue");

  // an error result stands alone and carries a zero value
  a_bad_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.bad_symbol) |-> (out_ch.end_of_run && out_ch.value_out == '0))
    else $error("malformed error result");

  // a result only starts from a record waiting in the queue
  a_result_follows_record: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_ch.valid)) |-> $past(q_head_valid))
    else $error("result without a queued record");

endmodule

FILE: test/b32c_codec_checker.sv
`timescale 1ns / 1ps
// result checker for the base32 codec: watches all three channels, predicts and compares
module b32c_codec_checker
  import b32c_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  b32c_in_if   in_ch,
  b32c_out_if  out_ch,
  b32c_cfg_if  cfg_ch,
  output int   mismatch_count,
  output int   pending
);

  localparam int PrintCap = 40;

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             bad;
    logic             eor;
    logic             eom;
  } codec_result_t;

  // predicted copy of the alphabet and of the message state
  logic [CfgDataW-1:0] alpha_words [NumWords];
  logic [StoreW-1:0]   bit_store;
  int                  bits_held;
  logic                err_latched;
  codec_result_t       expected_results [$];

  function automatic logic [ByteW-1:0] symbol_at(input logic [SymW-1:0] idx);
    return alpha_words[idx[4:2]][idx[1:0]*ByteW +: ByteW];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PrintCap) begin
      $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic clear_message();
    bit_store   = '0;
    bits_held   = 0;
    err_latched = 1'b0;
  endtask

  // expected results of one input transaction
  task automatic predict_item(input logic act, input logic [ByteW-1:0] din, input logic last);
    codec_result_t res [MaxRes];
    int            n;
    int            found;
    n     = 0;
    found = -1;
    for (int k = 0; k < MaxRes; k++) res[k] = '0;

    // latched error: nothing comes out, a last item still clears
    if (err_latched) begin
      if (last) clear_message();
      return;
    end

    if (act == ActEncode) begin
      // only the newest four leftover bits survive the byte shifted in
      if (bits_held > 4) bits_held = 4;
      bit_store = {bit_store[3:0], din};
      bits_held += ByteW;
      while (bits_held >= SymW) begin
        bits_held -= SymW;
        res[n].value = symbol_at(SymW'(bit_store >> bits_held));
        n++;
      end
      // flush leftover bits as one zero-filled symbol
      if (last && bits_held > 0) begin
        res[n].value = symbol_at(SymW'(bit_store << (SymW - bits_held)));
        n++;
        bits_held = 0;
      end
    end else begin
      // lowest matching index wins
      for (int j = 0; j < AlphaLen; j++) begin
        if (found < 0 && symbol_at(SymW'(j)) == din) found = j;
      end
      if (found < 0) begin
        res[n].bad = 1'b1;
        n++;
        err_latched = 1'b1;
      end else begin
        bit_store = {bit_store[StoreW-SymW-1:0], SymW'(found)};
        bits_held += SymW;
        if (bits_held >= ByteW) begin
          bits_held -= ByteW;
          res[n].value = ByteW'(bit_store >> bits_held);
          n++;
        end
      end
    end
    bit_store &= StoreW'((1 << bits_held) - 1);

    if (n > 0) res[n-1].eor = 1'b1;
    for (int k = 0; k < n; k++) begin
      res[k].eom = last;
      expected_results.insert(expected_results.size(), res[k]);
    end
    if (last) clear_message();
  endtask

  // compare one result transaction with the oldest prediction
  task automatic check_result();
    codec_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing expected", out_ch.value_out, 0);
      return;
    end
    want = expected_results.pop_front();
    if (out_ch.value_out !== want.value)
      report_mismatch("value_out", out_ch.value_out, want.value);
    if (out_ch.bad_symbol !== want.bad)
      report_mismatch("bad_symbol", out_ch.bad_symbol, want.bad);
    if (out_ch.end_of_run !== want.eor)
      report_mismatch("end_of_run", out_ch.end_of_run, want.eor);
    if (out_ch.end_of_message !== want.eom)
      report_mismatch("end_of_message", out_ch.end_of_message, want.eom);
  endtask

  // transaction monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NumWords; k++) alpha_words[k] = AlphaReset[k*ChPerWord +: ChPerWord];
      clear_message();
      expected_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index < NumWords)
        alpha_words[cfg_ch.index] = cfg_ch.data;
      if (in_ch.valid && in_ch.ready)
        predict_item(in_ch.action, in_ch.data_in, in_ch.last_item);
      if (out_ch.valid && out_ch.ready)
        check_result();
    end
    pending = expected_results.size();
  end

endmodule

FILE: test/tb_base32_codec_custom_alphabet.sv
`timescale 1ns / 1ps
// testbench top for the base32 codec: clock, reset, stimulus, receiver and verdict
module tb_base32_codec_custom_alphabet;
  import b32c_pkg::*;

  localparam int CycleLimit   = 300000;
  localparam int SettleCycles = 20;
  localparam int HoldCycles   = 80;

  logic clk = 1'b0;
  logic rst_n;

  int mismatches;
  int results_pending;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_token;
  int hold_seen;
  int hold_left;
  int items_sent;
  int cycles;

  // stimulus-side view of the alphabet, for picking decode characters
  logic [CfgDataW-1:0] cur_words [NumWords];

  b32c_in_if  in_ch ();
  b32c_out_if out_ch ();
  b32c_cfg_if cfg_ch ();

  base32_codec_custom_alphabet i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  b32c_codec_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_ch         (cfg_ch),
    .mismatch_count (mismatches),
    .pending        (results_pending)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random ready, or a long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_seen = 0;
      hold_left = 0;
    end else if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_left = HoldCycles;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic logic [ByteW-1:0] alphabet_char(input logic [SymW-1:0] idx);
    return cur_words[idx[4:2]][idx[1:0]*ByteW +: ByteW];
  endfunction

  // a character found nowhere in the current alphabet
  function automatic logic [ByteW-1:0] unknown_char();
    logic [ByteW-1:0] c;
    bit               hit;
    do begin
      c   = ByteW'($urandom);
      hit = 1'b0;
      for (int j = 0; j < AlphaLen; j++) begin
        if (alphabet_char(SymW'(j)) == c) hit = 1'b1;
      end
    end while (hit);
    return c;
  endfunction

  // offer one item and wait for its transaction, then maybe idle
  task automatic send_item(input logic act, input logic [ByteW-1:0] din, input logic last);
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.data_in   <= din;
    in_ch.last_item <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // stop offering until every predicted result has come out
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // one register write transaction
  task automatic program_word(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] word);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= word;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx < NumWords) cur_words[idx] = word;
    @(posedge clk);
  endtask

  // one random message: mostly well-formed encode or decode runs, some noise
  task automatic send_message();
    int               len;
    int               kind;
    logic             act;
    logic             last;
    logic [ByteW-1:0] c;
    len  = $urandom_range(1, 7);
    kind = $urandom_range(0, 9);
    for (int i = 0; i < len; i++) begin
      last = (i == len - 1);
      if (kind < 4) begin
        act = ActEncode;
        c   = ByteW'($urandom);
      end else if (kind < 8) begin
        act = ActDecode;
        c   = ($urandom_range(0, 24) == 0) ? unknown_char()
                                            : alphabet_char(SymW'($urandom_range(0, 31)));
      end else if (kind == 8) begin
        act = 1'($urandom);
        c   = (act == ActDecode) ? alphabet_char(SymW'($urandom_range(0, 31)))
                                 : ByteW'($urandom);
      end else begin
        act  = 1'($urandom);
        c    = ByteW'($urandom);
        last = last | ($urandom_range(0, 3) == 0);
      end
      send_item(act, c, last);
    end
  endtask

  task automatic run_random(input int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) send_message();
  endtask

  // cycle limit
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("base32_codec_custom_alphabet test failed");
    $finish;
  end

  // stimulus and verdict
  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ActEncode;
    in_ch.data_in   = '0;
    in_ch.last_item = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    out_ch.ready    = 1'b0;
    send_idle_pct   = 19;
    recv_idle_pct   = 60;
    hold_token      = 0;
    items_sent      = 0;
    for (int k = 0; k < NumWords; k++) cur_words[k] = AlphaReset[k*ChPerWord +: ChPerWord];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items on the reset alphabet
    send_item(ActEncode, 8'h00, 1'b1);
    send_item(ActEncode, 8'hFF, 1'b1);
    // four held bits on a last item: two groups plus a flush
    send_item(ActEncode, 8'hA5, 1'b0);
    send_item(ActEncode, 8'h5A, 1'b0);
    send_item(ActEncode, 8'hFF, 1'b0);
    send_item(ActEncode, 8'h00, 1'b1);
    // decode with trailing bits dropped
    send_item(ActDecode, "M", 1'b0);
    send_item(ActDecode, "Y", 1'b0);
    send_item(ActDecode, "2", 1'b1);
    // unknown character, then ignored items until the last one
    send_item(ActDecode, "a", 1'b0);
    send_item(ActEncode, 8'h12, 1'b0);
    send_item(ActDecode, "B", 1'b0);
    send_item(ActDecode, "C", 1'b1);
    send_item(ActDecode, 8'h00, 1'b1);
    // encode after decode leftovers
    send_item(ActDecode, "Z", 1'b0);
    send_item(ActDecode, "Z", 1'b0);
    send_item(ActDecode, "Z", 1'b0);
    send_item(ActEncode, 8'hFF, 1'b1);
    send_item(ActDecode, "A", 1'b0);
    send_item(ActDecode, "6", 1'b1);
    send_item(ActEncode, 8'h7F, 1'b0);
    send_item(ActDecode, "7", 1'b1);
    drain_results();

    // random alphabet in every word, plus writes to unused indexes
    for (int k = 0; k < NumWords; k++) program_word(CfgIdxW'(k), $urandom());
    program_word(CfgIdxW'(NumWords), $urandom());
    program_word('1, $urandom());
    run_random(30);
    drain_results();

    // all entries 0xFF: duplicates everywhere
    for (int k = 0; k < NumWords; k++) program_word(CfgIdxW'(k), '1);
    send_item(ActDecode, 8'hFF, 1'b0);
    send_item(ActDecode, 8'hFF, 1'b0);
    send_item(ActDecode, 8'h00, 1'b1);
    send_item(ActEncode, 8'h3C, 1'b1);
    drain_results();

    // all entries 0x00
    for (int k = 0; k < NumWords; k++) program_word(CfgIdxW'(k), '0);
    send_item(ActDecode, 8'h00, 1'b0);
    send_item(ActDecode, 8'h00, 1'b0);
    send_item(ActEncode, 8'hFF, 1'b1);
    send_item(ActDecode, 8'hFF, 1'b1);
    drain_results();

    // swapped idling, with a long receiver hold-off to fill the queue
    send_idle_pct = 60;
    recv_idle_pct <= 19;
    for (int k = 0; k < NumWords; k++) program_word(CfgIdxW'(k), $urandom());
    hold_token <= hold_token + 1;
    run_random(30);
    drain_results();

    // no idling, back to the reset alphabet, with a pause mid-way
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    for (int k = 0; k < NumWords; k++)
      program_word(CfgIdxW'(k), AlphaReset[k*ChPerWord +: ChPerWord]);
    run_random(15);
    drain_results();
    run_random(15);
    drain_results();

    if (mismatches == 0) begin
      $display("base32_codec_custom_alphabet test passed");
    end else begin
      $display("base32_codec_custom_alphabet test failed");
    end
    $finish;
  end

endmodule
